// ===== rtl/gaussian_noise_per_channel_core_macros.svh =====
// assertion helpers for the gaussian noise core
`ifndef GAUSSIAN_NOISE_PER_CHANNEL_CORE_MACROS_SVH
`define GAUSSIAN_NOISE_PER_CHANNEL_CORE_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define GNPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gnpc assertion failed");

// next-cycle implication, skipped while reset is high
`define GNPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gnpc assertion failed");

`endif

// ===== rtl/gnpc_pkg.sv =====
`timescale 1ns / 1ps

package gnpc_pkg;

   // lcg step r = r*2053 + 13849 mod 2^16
   localparam logic [31:0] LCG_MUL = 32'd2053;
   localparam logic [31:0] LCG_ADD = 32'd13849;

   // draws per sample and the step counter width
   localparam int unsigned DRAWS = 12;
   localparam int unsigned CNT_W = 4;

   // sum of twelve uniforms is centred by 6 * 65536
   localparam logic signed [19:0] SUM_CENTRE = 20'sd393216;

   // widths of the fields
   localparam int unsigned SEED_W   = 16;
   localparam int unsigned SUM_W    = 20;
   localparam int unsigned SAMPLE_W = 19;

   // channel compare width, wide enough for the largest channel count
   localparam int unsigned CH_CMP_W = 11;

   // request kinds
   localparam logic KIND_DRAW = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   // result of the lcg sequencer
   typedef struct packed {
      logic                     done;
      logic [SEED_W-1:0]        seed;
      logic signed [SUM_W-1:0]  centred;
   } lcg_res_type;

   // control sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_START,
      ST_RUN,
      ST_SCALE,
      ST_HOLD
   } state_type;

endpackage

// ===== rtl/gnpc_seed_mem.sv =====
`timescale 1ns / 1ps

module gnpc_seed_mem
   import gnpc_pkg::*;
#(
   parameter int unsigned DEPTH = 65,
   parameter int unsigned IDX_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [SEED_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [SEED_W-1:0] rd_data
);

   logic [SEED_W-1:0] seed_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [SEED_W-1:0] rd_data_ff;

   // seed storage, single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         seed_ff[wr_addr] <= wr_data;
      end
   end

   // entries read as zero until written after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? seed_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gnpc_lcg.sv =====
`timescale 1ns / 1ps

module gnpc_lcg
   import gnpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SEED_W-1:0] seed,
   output lcg_res_type       res
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SEED_W-1:0]       r_ff, r_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic [SEED_W-1:0]       r_next;

   // one lcg step per cycle
   assign r_next = SEED_W'(32'(r_ff) * LCG_MUL + LCG_ADD);

   // step sequencing and centred accumulation
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         r_in    = seed;
         acc_in  = -SUM_CENTRE;
      end else if (busy_ff) begin
         r_in   = r_next;
         acc_in = acc_ff + signed'({{(SUM_W-SEED_W){1'b0}}, r_next});
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DRAWS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      acc_ff <= acc_in;
   end

   assign res.done    = done_ff;
   assign res.seed    = r_ff;
   assign res.centred = acc_ff;

endmodule

// ===== rtl/gnpc_scale.sv =====
`timescale 1ns / 1ps

module gnpc_scale
   import gnpc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [15:0]       mean,
   input  logic signed [15:0]       spread,
   input  logic signed [SUM_W-1:0]  centred,
   output logic                     out_valid,
   output logic [SAMPLE_W-1:0]      sample
);

   logic                     v1_ff, v2_ff;
   logic signed [35:0]       prod_ff;
   logic signed [15:0]       mean_ff;
   logic [SAMPLE_W-1:0]      sample_ff;
   logic signed [37:0]       num;
   logic signed [21:0]       quot;

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // stage one: spread times centred sum
   always_ff @(posedge clock) begin
      if (in_valid) begin
         prod_ff <= 36'(spread * centred);
         mean_ff <= mean;
      end
   end

   // stage two: add mean, divide by 2^16 truncating toward zero
   always_comb begin
      num  = 38'(signed'({mean_ff, 16'h0000})) + 38'(prod_ff);
      quot = 22'(num >>> 16);
      if (num[37] && (num[15:0] != 16'h0000)) begin
         quot = quot + 22'sd1;
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         sample_ff <= quot[SAMPLE_W-1:0];
      end
   end

   assign out_valid = v2_ff;
   assign sample    = sample_ff;

endmodule

// ===== rtl/gaussian_noise_per_channel_core.sv =====
`timescale 1ns / 1ps
// draw: rsp_tvalid rises after the seed read, the lcg start, the twelve lcg steps of the shared
// step unit, the done cycle, a two-stage scale and the result register; no new draw is accepted
// until the result is loaded into the result register, which waits while the result side stalls
// seed load: taken in the idle state, no result; the block stays ready for the next request
// reset (synchronous, active high) clears control and marks every seed as zero

module gaussian_noise_per_channel_core
   import gnpc_pkg::*;
#(
   parameter int unsigned CHANNELS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] channel, [23:8] mean, [39:24] spread, [55:40] seed_value
   input  logic [55:0] req_tdata,
   // [0] kind
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [18:0] sample, [23:19] zero
   output logic [23:0] rsp_tdata
);

   localparam int unsigned DEPTH = CHANNELS + 1;
   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] SPARE_IDX = IDX_W'(CHANNELS);
   localparam logic [CH_CMP_W-1:0] CH_LIMIT = CH_CMP_W'(CHANNELS);

   state_type state_ff, state_in;

   logic signed [7:0]    req_channel;
   logic signed [15:0]   req_mean, req_spread;
   logic [SEED_W-1:0]    req_seed;
   logic [CH_CMP_W-1:0]  ch_wide;
   logic [IDX_W-1:0]     req_idx;
   logic                 req_fire, load_fire, draw_fire;

   logic [IDX_W-1:0]     idx_ff;
   logic signed [15:0]   mean_ff, spread_ff;

   logic                 mem_wr_en, mem_rd_en, lcg_start, scale_in;
   logic [IDX_W-1:0]     mem_wr_addr;
   logic [SEED_W-1:0]    mem_wr_data, mem_rd_data;
   lcg_res_type          lcg_res;
   logic                 scale_valid;
   logic [SAMPLE_W-1:0]  scale_sample;

   logic                 rsp_free, rsp_load;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]  rsp_sample_ff;

   // request field unpack
   assign req_channel = req_tdata[7:0];
   assign req_mean    = req_tdata[23:8];
   assign req_spread  = req_tdata[39:24];
   assign req_seed    = req_tdata[55:40];

   // entry select, negative or too-large channels use the spare entry
   assign ch_wide = {{(CH_CMP_W-7){1'b0}}, req_channel[6:0]};
   assign req_idx = (req_channel[7] || (ch_wide >= CH_LIMIT)) ? SPARE_IDX
                                                              : ch_wide[IDX_W-1:0];

   assign req_fire  = req_tvalid && req_tready;
   assign load_fire = req_fire && (req_tuser == KIND_LOAD);
   assign draw_fire = req_fire && (req_tuser == KIND_DRAW);

   // result register free when empty or being taken
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (draw_fire) state_in = ST_READ;
         end
         ST_READ:  state_in = ST_START;
         ST_START: state_in = ST_RUN;
         ST_RUN: begin
            if (lcg_res.done) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (scale_valid) state_in = rsp_free ? ST_IDLE : ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      mem_rd_en  = 1'b0;
      lcg_start  = 1'b0;
      scale_in   = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_READ:  mem_rd_en  = 1'b1;
         ST_START: lcg_start  = 1'b1;
         ST_RUN:   scale_in   = lcg_res.done;
         ST_SCALE: rsp_load   = scale_valid && rsp_free;
         ST_HOLD:  rsp_load   = rsp_free;
         default: ;
      endcase
   end

   // memory write port: seed load or draw writeback
   assign mem_wr_en   = load_fire || scale_in;
   assign mem_wr_addr = load_fire ? req_idx : idx_ff;
   assign mem_wr_data = load_fire ? req_seed : lcg_res.seed;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // draw operands
   always_ff @(posedge clock) begin
      if (draw_fire) begin
         idx_ff    <= req_idx;
         mean_ff   <= req_mean;
         spread_ff <= req_spread;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sample_ff <= scale_sample;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(24-SAMPLE_W){1'b0}}, rsp_sample_ff};

   gnpc_seed_mem #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_seed_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (idx_ff),
      .rd_data (mem_rd_data)
   );

   gnpc_lcg u_lcg (
      .clock (clock),
      .reset (reset),
      .start (lcg_start),
      .seed  (mem_rd_data),
      .res   (lcg_res)
   );

   gnpc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scale_in),
      .mean      (mean_ff),
      .spread    (spread_ff),
      .centred   (lcg_res.centred),
      .out_valid (scale_valid),
      .sample    (scale_sample)
   );

endmodule

// ===== rtl/gnpc_checker.sv =====
`timescale 1ns / 1ps
`include "gaussian_noise_per_channel_core_macros.svh"

module gnpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // a stalled result holds its value
   `GNPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // padding above the sample is always zero
   `GNPC_ASSERT_NOW(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[23:19] == 5'd0)

   // a draw transaction occupies the block for the following cycle
   `GNPC_ASSERT_NEXT(a_draw_busy, clock, reset, req_tvalid && req_tready && !req_tuser, !req_tready)

   // a seed load leaves the block ready again in the following cycle
   `GNPC_ASSERT_NEXT(a_load_fast, clock, reset, req_tvalid && req_tready && req_tuser, req_tready)

endmodule

bind gaussian_noise_per_channel_core gnpc_checker u_checker (.*);
